@@ src/imt_pkg.sv @@
// Shared widths, constants and handshake types of the linear motion tracker.
package imt_pkg;

	localparam int IN_W       = 16;
	localparam int IN_FIELDS  = 7;
	localparam int IN_DATA_W  = IN_FIELDS * IN_W;
	localparam int AXES       = 3;
	localparam int ACC_W      = 23;
	localparam int POS_OUT_W  = 32;
	localparam int OUT_DATA_W = AXES * POS_OUT_W + AXES * ACC_W + AXES;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;
	localparam int LIMIT_W    = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = CFG_IDX_W'(2);

	localparam logic [CFG_DATA_W-1:0] DEADBAND_RST  = CFG_DATA_W'(39322);
	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = CFG_DATA_W'(78643);
	localparam logic [LIMIT_W-1:0]    LIMIT_RST     = LIMIT_W'(20);
	localparam logic [LIMIT_W-1:0]    STILL_MAX     = '1;

	localparam int MUL_W     = 16;
	localparam int MUL_DIG   = 4;
	localparam int MUL_STEPS = MUL_W / MUL_DIG;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int G_W         = 35;
	localparam int G_ALIGN     = 15;
	localparam int MAG_W       = 34;
	localparam int SCALED_W    = 40;
	localparam int SCALE_MUL   = 49;
	localparam int SCALE_SHIFT = 12;
	localparam int SCALE_DIV   = 5;
	localparam int POS_DIV     = 70;

	localparam int NV_W   = 26;
	localparam int SUM_W  = 28;
	localparam int STEP_W = 32;
	localparam int SQ_W   = 23;
	localparam int PQ_W   = 26;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic [2*MUL_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

@@ src/imt_serial_mul.sv @@
// Radix-16 serial unsigned multiplier, one multiplier digit per cycle.
module imt_serial_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  imt_pkg::mul_req_t   req,
	output imt_pkg::mul_rsp_t   rsp
);

	localparam int W  = imt_pkg::MUL_W;
	localparam int DG = imt_pkg::MUL_DIG;

	logic                            busy_q;
	logic                            done_q;
	logic [imt_pkg::MUL_CNT_W-1:0]   cnt_q;
	logic [W-1:0]                    a_q;
	logic [W-1:0]                    b_q;
	logic [2*W-1:0]                  acc_q;
	logic [W+DG-1:0]                 part;
	logic [2*W+DG-1:0]               sum;

	assign part = (W+DG)'(a_q) * (W+DG)'(b_q[DG-1:0]);
	assign sum  = {{DG{1'b0}}, acc_q} + {part, {W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == imt_pkg::MUL_CNT_W'(imt_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= sum[2*W+DG-1:DG];
			b_q   <= b_q >> DG;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

@@ src/imt_serial_div.sv @@
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module imt_serial_div (
	input  logic                clk,
	input  logic                arst_n,
	input  imt_pkg::div_req_t   req,
	output imt_pkg::div_rsp_t   rsp
);

	localparam int W = imt_pkg::DIV_W;

	logic                            busy_q;
	logic                            done_q;
	logic [imt_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    quo_q;
	logic [W-1:0]                    dvs_q;
	logic [W:0]                      rem_sh;
	logic [W:0]                      diff;
	logic                            fits;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign fits   = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == imt_pkg::DIV_CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

@@ src/imu_linear_motion_tracker.sv @@
// Top level of the linear motion tracker: sample sequencer, per-axis state and stream ports.
//
// One sample (three accelerometer axes in 1/8192 g and a Q1.14 orientation quaternion) goes in
// per input transaction and one result (Q16.16 position, filtered linear acceleration and the
// moving flag of each axis) comes out per output transaction, in order. Samples are worked on
// one at a time: the time a sample takes from acceptance to a loaded result is set by the shared
// bit-serial divider (one division per axis for the m/s^2 scaling and two more for each
// integrating axis) and the radix-16 serial multiplier (eight gravity products per sample).
// The result sits in an output register, so the next sample is accepted while it waits to
// be taken. Configuration writes are taken in every cycle and belong between samples.
module imu_linear_motion_tracker #(
	parameter int RUN_COUNT_BITS = 8,
	parameter int POSITION_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z
	input  logic [imt_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pos_x, pos_y, pos_z, lin_acc_x, lin_acc_y, lin_acc_z, moving_x, moving_y, moving_z
	output logic [imt_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [imt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW   = imt_pkg::IN_W;
	localparam int AW   = imt_pkg::ACC_W;
	localparam int GW   = imt_pkg::G_W;
	localparam int SW   = imt_pkg::STEP_W;
	localparam int OPW  = imt_pkg::POS_OUT_W;
	localparam int PSUM_W = ((POSITION_BITS > imt_pkg::PQ_W + 1) ?
		POSITION_BITS : imt_pkg::PQ_W + 1) + 1;
	localparam int POS_EXT_W = (POSITION_BITS > OPW) ? POSITION_BITS : OPW;

	localparam logic signed [PSUM_W-1:0] PMAX =
		PSUM_W'({1'b0, {(POSITION_BITS-1){1'b1}}});
	localparam logic signed [PSUM_W-1:0] PMIN = ~PMAX;
	localparam logic signed [POS_EXT_W-1:0] OUT_MAX = POS_EXT_W'({1'b0, {(OPW-1){1'b1}}});
	localparam logic signed [POS_EXT_W-1:0] OUT_MIN = ~OUT_MAX;
	localparam logic signed [SW:0] STEP_MAX = (SW+1)'({1'b0, {(SW-1){1'b1}}});
	localparam logic signed [SW:0] STEP_MIN = ~STEP_MAX;
	localparam logic signed [imt_pkg::SUM_W-1:0] ACC_HI =
		imt_pkg::SUM_W'({1'b0, {(AW-1){1'b1}}});
	localparam logic signed [imt_pkg::SUM_W-1:0] ACC_LO = ~ACC_HI;
	localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_G_ISSUE  = 4'd1;
	localparam logic [3:0] S_G_WAIT   = 4'd2;
	localparam logic [3:0] S_D_SUB    = 4'd3;
	localparam logic [3:0] S_D_SCALE  = 4'd4;
	localparam logic [3:0] S_N_WAIT   = 4'd5;
	localparam logic [3:0] S_F_CALC   = 4'd6;
	localparam logic [3:0] S_F_DEAD   = 4'd7;
	localparam logic [3:0] S_R_WAIT   = 4'd8;
	localparam logic [3:0] S_S_WAIT   = 4'd9;
	localparam logic [3:0] S_S_ADD    = 4'd10;
	localparam logic [3:0] S_P_ISSUE  = 4'd11;
	localparam logic [3:0] S_P_WAIT   = 4'd12;
	localparam logic [3:0] S_P_ADD    = 4'd13;
	localparam logic [3:0] S_AXIS_END = 4'd14;
	localparam logic [3:0] S_OUT      = 4'd15;

	logic [3:0] state_q;
	logic [2:0] term_q;
	logic [1:0] axis_q;
	logic       out_valid_q;

	logic [imt_pkg::CFG_DATA_W-1:0] deadband_q;
	logic [imt_pkg::CFG_DATA_W-1:0] thresh_q;
	logic [imt_pkg::LIMIT_W-1:0]    limit_q;

	logic signed [IW-1:0] ax_q, ay_q, az_q, qw_q, qx_q, qy_q, qz_q;
	logic signed [GW-1:0] gacc_q;
	logic signed [GW-1:0] d_q;
	logic                 dneg_q;
	logic signed [AW-1:0] f_q;
	logic [AW-1:0]        fmag_q;
	logic                 fneg_q;

	logic signed [AW-1:0]            filt_q  [imt_pkg::AXES];
	logic [imt_pkg::LIMIT_W-1:0]     still_q [imt_pkg::AXES];
	logic [RUN_COUNT_BITS-1:0]       run_q   [imt_pkg::AXES];
	logic signed [SW-1:0]            step_q  [imt_pkg::AXES];
	logic signed [POSITION_BITS-1:0] pos_q   [imt_pkg::AXES];

	logic signed [AW-1:0]  res_lin_q [imt_pkg::AXES];
	logic                  res_mv_q  [imt_pkg::AXES];
	logic signed [OPW-1:0] res_pos_q [imt_pkg::AXES];
	logic [imt_pkg::OUT_DATA_W-1:0] out_data_q;

	imt_pkg::mul_req_t mul_req;
	imt_pkg::mul_rsp_t mul_rsp;
	imt_pkg::div_req_t div_req;
	imt_pkg::div_rsp_t div_rsp;

	logic signed [IW-1:0]                 op_a, op_b, acc_sel;
	logic                                 t_dbl, t_neg, t_last;
	logic [IW-1:0]                        a_mag, b_mag;
	logic                                 prod_neg;
	logic [2*imt_pkg::MUL_W:0]            prod_mag;
	logic signed [2*imt_pkg::MUL_W:0]     prod_s;
	logic signed [GW-1:0]                 term_val, gacc_next, d_next;
	logic [GW-1:0]                        dmag_full;
	logic [imt_pkg::SCALED_W-1:0]         scaled;
	logic [imt_pkg::NV_W-1:0]             nv_mag;
	logic signed [imt_pkg::NV_W:0]        nv;
	logic signed [imt_pkg::SUM_W-1:0]     fsum, fhalf;
	logic signed [AW-1:0]                 fclamp;
	logic [AW-1:0]                        fmag, fmag_fin;
	logic                                 dead;
	logic signed [AW-1:0]                 ffin;
	logic [imt_pkg::LIMIT_W-1:0]          still_cur, still_new;
	logic                                 moving, integ;
	logic [RUN_COUNT_BITS-1:0]            run_cur, run_new;
	logic [imt_pkg::SQ_W-1:0]             sq_mag;
	logic signed [imt_pkg::SQ_W:0]        sq_s;
	logic signed [SW:0]                   ssum;
	logic signed [SW-1:0]                 step_cur, step_new;
	logic [SW-1:0]                        smag;
	logic [imt_pkg::PQ_W-1:0]             pq_mag;
	logic signed [imt_pkg::PQ_W:0]        pq_s;
	logic signed [PSUM_W-1:0]             psum;
	logic signed [POSITION_BITS-1:0]      pos_cur, pos_new;
	logic signed [POS_EXT_W-1:0]          pos_ext;
	logic signed [OPW-1:0]                pos_out;
	logic                                 out_free;
	logic                                 in_take;

	assign s_tready  = (state_q == S_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		op_a   = qx_q;
		op_b   = qz_q;
		t_dbl  = 1'b1;
		t_neg  = 1'b0;
		t_last = 1'b0;
		unique case (term_q)
			3'd0: begin
				op_a = qx_q; op_b = qz_q;
			end
			3'd1: begin
				op_a = qw_q; op_b = qy_q; t_neg = 1'b1; t_last = 1'b1;
			end
			3'd2: begin
				op_a = qw_q; op_b = qx_q;
			end
			3'd3: begin
				op_a = qy_q; op_b = qz_q; t_last = 1'b1;
			end
			3'd4: begin
				op_a = qw_q; op_b = qw_q; t_dbl = 1'b0;
			end
			3'd5: begin
				op_a = qx_q; op_b = qx_q; t_dbl = 1'b0; t_neg = 1'b1;
			end
			3'd6: begin
				op_a = qy_q; op_b = qy_q; t_dbl = 1'b0; t_neg = 1'b1;
			end
			3'd7: begin
				op_a = qz_q; op_b = qz_q; t_dbl = 1'b0; t_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		unique case (axis_q)
			2'd0:    acc_sel = ax_q;
			2'd1:    acc_sel = ay_q;
			default: acc_sel = az_q;
		endcase
	end

	always_comb begin
		a_mag     = op_a[IW-1] ? IW'(-op_a) : IW'(op_a);
		b_mag     = op_b[IW-1] ? IW'(-op_b) : IW'(op_b);
		prod_neg  = op_a[IW-1] ^ op_b[IW-1];
		prod_mag  = {1'b0, mul_rsp.prod};
		prod_s    = prod_neg ? -$signed(prod_mag) : $signed(prod_mag);
		term_val  = t_dbl ? (GW'(prod_s) <<< 1) : GW'(prod_s);
		gacc_next = t_neg ? gacc_q - term_val : gacc_q + term_val;
		d_next    = (GW'(acc_sel) <<< imt_pkg::G_ALIGN) - gacc_q;

		dmag_full = d_q[GW-1] ? GW'(-d_q) : GW'(d_q);
		scaled    = imt_pkg::SCALED_W'(dmag_full[imt_pkg::MAG_W-1:0]) *
			imt_pkg::SCALED_W'(imt_pkg::SCALE_MUL);

		nv_mag = div_rsp.quo[imt_pkg::NV_W-1:0];
		nv     = dneg_q ? -$signed({1'b0, nv_mag}) : $signed({1'b0, nv_mag});
		fsum   = imt_pkg::SUM_W'(nv) + imt_pkg::SUM_W'(filt_q[axis_q]);
		fhalf  = fsum >>> 1;
		if (fhalf > ACC_HI) begin
			fclamp = AW'(ACC_HI);
		end else if (fhalf < ACC_LO) begin
			fclamp = AW'(ACC_LO);
		end else begin
			fclamp = fhalf[AW-1:0];
		end

		fmag      = f_q[AW-1] ? AW'(-f_q) : AW'(f_q);
		dead      = (fmag <= AW'(deadband_q));
		ffin      = dead ? '0 : f_q;
		fmag_fin  = dead ? '0 : fmag;
		still_cur = still_q[axis_q];
		if (!dead) begin
			still_new = '0;
		end else if (still_cur == imt_pkg::STILL_MAX) begin
			still_new = still_cur;
		end else begin
			still_new = still_cur + 1'b1;
		end
		moving  = (still_new < limit_q);
		integ   = (fmag_fin > AW'(thresh_q)) && moving;
		run_cur = run_q[axis_q];
		run_new = (run_cur == RUN_MAX) ? run_cur : run_cur + 1'b1;

		step_cur = step_q[axis_q];
		sq_mag   = div_rsp.quo[imt_pkg::SQ_W-1:0];
		sq_s     = fneg_q ? -$signed({1'b0, sq_mag}) : $signed({1'b0, sq_mag});
		ssum     = (SW+1)'(step_cur) + (SW+1)'(sq_s);
		if (ssum > STEP_MAX) begin
			step_new = SW'(STEP_MAX);
		end else if (ssum < STEP_MIN) begin
			step_new = SW'(STEP_MIN);
		end else begin
			step_new = ssum[SW-1:0];
		end
		smag = step_cur[SW-1] ? SW'(-step_cur) : SW'(step_cur);

		pos_cur = pos_q[axis_q];
		pq_mag  = div_rsp.quo[imt_pkg::PQ_W-1:0];
		pq_s    = step_cur[SW-1] ? -$signed({1'b0, pq_mag}) : $signed({1'b0, pq_mag});
		psum    = PSUM_W'(pos_cur) + PSUM_W'(pq_s);
		if (psum > PMAX) begin
			pos_new = POSITION_BITS'(PMAX);
		end else if (psum < PMIN) begin
			pos_new = POSITION_BITS'(PMIN);
		end else begin
			pos_new = psum[POSITION_BITS-1:0];
		end

		pos_ext = POS_EXT_W'(pos_cur);
		if (pos_ext > OUT_MAX) begin
			pos_out = OPW'(OUT_MAX);
		end else if (pos_ext < OUT_MIN) begin
			pos_out = OPW'(OUT_MIN);
		end else begin
			pos_out = pos_ext[OPW-1:0];
		end
	end

	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			S_G_ISSUE: begin
				mul_req.start = 1'b1;
				mul_req.a     = a_mag;
				mul_req.b     = b_mag;
			end
			S_D_SCALE: begin
				div_req.start    = 1'b1;
				div_req.dividend = imt_pkg::DIV_W'(
					scaled[imt_pkg::SCALED_W-1:imt_pkg::SCALE_SHIFT]);
				div_req.divisor  = imt_pkg::DIV_W'(imt_pkg::SCALE_DIV);
			end
			S_F_DEAD: begin
				mul_req.start = integ;
				mul_req.a     = imt_pkg::MUL_W'(run_new);
				mul_req.b     = imt_pkg::MUL_W'(run_new);
			end
			S_R_WAIT: begin
				div_req.start    = mul_rsp.done;
				div_req.dividend = imt_pkg::DIV_W'(fmag_q);
				div_req.divisor  = mul_rsp.prod;
			end
			S_P_ISSUE: begin
				div_req.start    = 1'b1;
				div_req.dividend = imt_pkg::DIV_W'(smag);
				div_req.divisor  = imt_pkg::DIV_W'(imt_pkg::POS_DIV);
			end
			default: begin
			end
		endcase
	end

	imt_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	imt_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= imt_pkg::DEADBAND_RST;
			thresh_q   <= imt_pkg::THRESHOLD_RST;
			limit_q    <= imt_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				imt_pkg::CFG_DEADBAND:  deadband_q <= cfg_data;
				imt_pkg::CFG_THRESHOLD: thresh_q   <= cfg_data;
				imt_pkg::CFG_LIMIT:     limit_q    <= cfg_data[imt_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= '0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < imt_pkg::AXES; k++) begin
				filt_q[k]  <= '0;
				still_q[k] <= '0;
				run_q[k]   <= '0;
				step_q[k]  <= '0;
				pos_q[k]   <= '0;
			end
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						term_q  <= '0;
						axis_q  <= '0;
						state_q <= S_G_ISSUE;
					end
				end
				S_G_ISSUE: state_q <= S_G_WAIT;
				S_G_WAIT: begin
					if (mul_rsp.done) begin
						term_q  <= term_q + 1'b1;
						state_q <= t_last ? S_D_SUB : S_G_ISSUE;
					end
				end
				S_D_SUB:   state_q <= S_D_SCALE;
				S_D_SCALE: state_q <= S_N_WAIT;
				S_N_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_F_CALC;
					end
				end
				S_F_CALC: state_q <= S_F_DEAD;
				S_F_DEAD: begin
					filt_q[axis_q]  <= ffin;
					still_q[axis_q] <= still_new;
					if (integ) begin
						run_q[axis_q] <= run_new;
						state_q       <= S_R_WAIT;
					end else begin
						run_q[axis_q]  <= '0;
						step_q[axis_q] <= '0;
						state_q        <= S_AXIS_END;
					end
				end
				S_R_WAIT: begin
					if (mul_rsp.done) begin
						state_q <= S_S_WAIT;
					end
				end
				S_S_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_S_ADD;
					end
				end
				S_S_ADD: begin
					step_q[axis_q] <= step_new;
					state_q        <= S_P_ISSUE;
				end
				S_P_ISSUE: state_q <= S_P_WAIT;
				S_P_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_P_ADD;
					end
				end
				S_P_ADD: begin
					pos_q[axis_q] <= pos_new;
					state_q       <= S_AXIS_END;
				end
				S_AXIS_END: begin
					if (axis_q == 2'd2) begin
						axis_q  <= '0;
						state_q <= S_OUT;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_G_ISSUE;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ax_q   <= s_tdata[0*IW +: IW];
			ay_q   <= s_tdata[1*IW +: IW];
			az_q   <= s_tdata[2*IW +: IW];
			qw_q   <= s_tdata[3*IW +: IW];
			qx_q   <= s_tdata[4*IW +: IW];
			qy_q   <= s_tdata[5*IW +: IW];
			qz_q   <= s_tdata[6*IW +: IW];
			gacc_q <= '0;
		end else if (state_q == S_G_WAIT && mul_rsp.done) begin
			gacc_q <= gacc_next;
		end else if (state_q == S_AXIS_END) begin
			gacc_q <= '0;
		end
		if (state_q == S_D_SUB) begin
			d_q <= d_next;
		end
		if (state_q == S_D_SCALE) begin
			dneg_q <= d_q[GW-1];
		end
		if (state_q == S_F_CALC) begin
			f_q <= fclamp;
		end
		if (state_q == S_F_DEAD) begin
			fmag_q            <= fmag_fin;
			fneg_q            <= f_q[AW-1];
			res_lin_q[axis_q] <= ffin;
			res_mv_q[axis_q]  <= moving;
		end
		if (state_q == S_AXIS_END) begin
			res_pos_q[axis_q] <= pos_out;
		end
		if (state_q == S_OUT && out_free) begin
			out_data_q <= {res_mv_q[2], res_mv_q[1], res_mv_q[0],
				res_lin_q[2], res_lin_q[1], res_lin_q[0],
				res_pos_q[2], res_pos_q[1], res_pos_q[0]};
		end
	end

endmodule
